[rtl/core/hid_active_key_list_top_defines.svh]
// Assertion macros shared by the held-key list top level.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef HID_ACTIVE_KEY_LIST_TOP_DEFINES_SVH
`define HID_ACTIVE_KEY_LIST_TOP_DEFINES_SVH

`define HAKL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("held-key list check failed");

`define HAKL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("held-key list check failed");

`endif

[rtl/core/hakl_pkg.sv]
// Shared constants and controller/datapath interface types for the held-key list.
// No dependencies.
package hakl_pkg;

  localparam int MAX_KEYS = 6;
  localparam int CNT_W    = $clog2(MAX_KEYS + 1);
  localparam int IDX_W    = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;

  localparam logic [7:0] EMPTY_CODE = 8'hFF;

  typedef struct packed {
    logic capture;
    logic update;
    logic emit;
  } hakl_cmd_t;

  typedef struct packed {
    logic out_busy;
    logic last;
  } hakl_status_t;

endpackage

[rtl/core/hakl_ctrl.sv]
// Sequencing state machine for the held-key list.
// Depends on hakl_pkg for the command and status types.
module hakl_ctrl import hakl_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  hakl_status_t status,
  output hakl_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_UPDATE = 3'b010,
    ST_EMIT   = 3'b100
  } ctl_state_t;

  ctl_state_t state_r, state_nxt;

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.update  = 1'b0;
    cmd.emit    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        if (!status.out_busy) begin
          cmd.emit = 1'b1;
          if (status.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/core/hakl_datapath.sv]
// Key list registers, parallel search, close-up shift and output register.
// Depends on hakl_pkg for sizes, the empty code and the interface types.
module hakl_datapath import hakl_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  hakl_cmd_t    cmd,
  output hakl_status_t status,
  input  logic [7:0]   in_key_code,
  input  logic         in_key_is_modifier,
  input  logic         in_key_pressed,
  input  logic         cfg_wr_en,
  input  logic         cfg_wr_data,
  input  logic         out_ready,
  output logic         out_valid,
  output logic         out_list_changed,
  output logic         out_keyboard_off_notice,
  output logic         out_entry_valid,
  output logic [7:0]   out_entry_code,
  output logic         out_entry_is_modifier,
  output logic [2:0]   out_held_count,
  output logic         out_last_result
);

  logic [7:0]          codes_r [MAX_KEYS];
  logic [7:0]          codes_nxt [MAX_KEYS];
  logic [MAX_KEYS-1:0] mods_r, mods_nxt;
  logic [CNT_W-1:0]    total_r, total_nxt;
  logic [7:0]          ev_code_r;
  logic                ev_mod_r;
  logic                ev_press_r;
  logic                hit_r;
  logic [IDX_W-1:0]    hit_idx_r;
  logic                changed_r, changed_nxt;
  logic [IDX_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic                enabled_r;

  logic [MAX_KEYS-1:0] match;
  logic [IDX_W-1:0]    hit_idx;
  logic                entry_valid;
  logic                out_valid_r;
  logic                out_changed_r, out_off_r, out_entry_valid_r, out_mod_r, out_last_r;
  logic [7:0]          out_code_r;
  logic [2:0]          out_count_r;

  always_comb begin
    match   = '0;
    hit_idx = '0;
    for (int i = 0; i < MAX_KEYS; i++) begin
      match[i] = (CNT_W'(i) < total_r) && (codes_r[i] == in_key_code) &&
                 (mods_r[i] == in_key_is_modifier);
    end
    for (int i = MAX_KEYS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    codes_nxt   = codes_r;
    mods_nxt    = mods_r;
    total_nxt   = total_r;
    changed_nxt = changed_r;
    rd_idx_nxt  = rd_idx_r;
    if (cmd.update) begin
      rd_idx_nxt  = '0;
      changed_nxt = 1'b0;
      if (hit_r) begin
        if (!ev_press_r) begin
          for (int i = 0; i < MAX_KEYS - 1; i++) begin
            if (IDX_W'(i) >= hit_idx_r) begin
              codes_nxt[i] = codes_r[i+1];
              mods_nxt[i]  = mods_r[i+1];
            end
          end
          codes_nxt[MAX_KEYS-1] = EMPTY_CODE;
          mods_nxt[MAX_KEYS-1]  = 1'b0;
          total_nxt             = total_r - CNT_W'(1);
          changed_nxt           = 1'b1;
        end
      end else if (ev_press_r && (total_r < CNT_W'(MAX_KEYS))) begin
        for (int i = 0; i < MAX_KEYS; i++) begin
          if (CNT_W'(i) == total_r) begin
            codes_nxt[i] = ev_code_r;
            mods_nxt[i]  = ev_mod_r;
          end
        end
        total_nxt   = total_r + CNT_W'(1);
        changed_nxt = 1'b1;
      end
    end
    if (cmd.emit && !status.last) begin
      rd_idx_nxt = rd_idx_r + IDX_W'(1);
    end
  end

  assign entry_valid     = changed_r && enabled_r && (total_r != '0);
  assign status.last     = !entry_valid || ((CNT_W'(rd_idx_r) + CNT_W'(1)) == total_r);
  assign status.out_busy = out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_KEYS; i++) begin
        codes_r[i] <= EMPTY_CODE;
      end
      mods_r      <= '0;
      total_r     <= '0;
      enabled_r   <= 1'b1;
      out_valid_r <= 1'b0;
      changed_r   <= 1'b0;
      rd_idx_r    <= '0;
    end else begin
      codes_r   <= codes_nxt;
      mods_r    <= mods_nxt;
      total_r   <= total_nxt;
      changed_r <= changed_nxt;
      rd_idx_r  <= rd_idx_nxt;
      if (cfg_wr_en) begin
        enabled_r <= cfg_wr_data;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ev_code_r  <= in_key_code;
      ev_mod_r   <= in_key_is_modifier;
      ev_press_r <= in_key_pressed;
      hit_r      <= |match;
      hit_idx_r  <= hit_idx;
    end
    if (cmd.emit) begin
      out_changed_r     <= changed_r;
      out_off_r         <= changed_r && !enabled_r;
      out_entry_valid_r <= entry_valid;
      out_code_r        <= entry_valid ? codes_r[rd_idx_r] : EMPTY_CODE;
      out_mod_r         <= entry_valid ? mods_r[rd_idx_r] : 1'b0;
      out_count_r       <= 3'(total_r);
      out_last_r        <= status.last;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_list_changed        = out_changed_r;
  assign out_keyboard_off_notice = out_off_r;
  assign out_entry_valid         = out_entry_valid_r;
  assign out_entry_code          = out_code_r;
  assign out_entry_is_modifier   = out_mod_r;
  assign out_held_count          = out_count_r;
  assign out_last_result         = out_last_r;

endmodule

[rtl/core/hid_active_key_list_top.sv]
// Held-key list for a keyboard report: accepts key events and streams the list or a status beat.
// Top level joining hakl_ctrl and hakl_datapath; uses hakl_pkg and the assertion macro header.
// Each key event is searched against the held list in the cycle it is accepted, the list is
// updated in the next cycle, and the results then leave through an output register at one beat
// per cycle while the output side is ready, so an event yields N beats (one to MAX_KEYS);
// any output stall holds the beats back. A new event is taken only once the previous one has
// placed its final beat in the output register.
module hid_active_key_list_top import hakl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_key_code,
  input  logic       in_key_is_modifier,
  input  logic       in_key_pressed,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_list_changed,
  output logic       out_keyboard_off_notice,
  output logic       out_entry_valid,
  output logic [7:0] out_entry_code,
  output logic       out_entry_is_modifier,
  output logic [2:0] out_held_count,
  output logic       out_last_result
);

  `include "hid_active_key_list_top_defines.svh"

  hakl_cmd_t    cmd;
  hakl_status_t status;

  hakl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  hakl_datapath u_datapath (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cmd                     (cmd),
    .status                  (status),
    .in_key_code             (in_key_code),
    .in_key_is_modifier      (in_key_is_modifier),
    .in_key_pressed          (in_key_pressed),
    .cfg_wr_en               (cfg_wr_en),
    .cfg_wr_data             (cfg_wr_data),
    .out_ready               (out_ready),
    .out_valid               (out_valid),
    .out_list_changed        (out_list_changed),
    .out_keyboard_off_notice (out_keyboard_off_notice),
    .out_entry_valid         (out_entry_valid),
    .out_entry_code          (out_entry_code),
    .out_entry_is_modifier   (out_entry_is_modifier),
    .out_held_count          (out_held_count),
    .out_last_result         (out_last_result)
  );

  `HAKL_ASSERT_NEXT(a_no_accept_while_updating, in_valid && in_ready, !in_ready)
  `HAKL_ASSERT_NOW(a_entry_needs_change, out_valid && out_entry_valid,
                   out_list_changed && !out_keyboard_off_notice && (out_held_count != 3'd0))
  `HAKL_ASSERT_NOW(a_notice_is_single, out_valid && out_keyboard_off_notice,
                   out_list_changed && !out_entry_valid && out_last_result)
  `HAKL_ASSERT_NOW(a_no_change_is_single, out_valid && !out_list_changed,
                   !out_entry_valid && out_last_result && (out_entry_code == EMPTY_CODE))

endmodule
